// ----- rtl/qsr_pkg.sv -----
// Package for the price-ordered record sorter.
// Record type, widths and sequencer states; no dependencies.
package qsr_pkg;
	localparam int MaxRecordsDef = 64;
	localparam int PriceW = 32;
	localparam int QtyW = 16;
	localparam int TagW = 6;
	localparam int RecW = PriceW + QtyW + TagW;

	typedef struct packed {
		logic [PriceW-1:0] price;
		logic [QtyW-1:0]   qty;
		logic [TagW-1:0]   tag;
	} rec_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_POP,
		ST_POPW,
		ST_PIVR,
		ST_PIVW,
		ST_LRD,
		ST_LCHK,
		ST_RRD,
		ST_RCHK,
		ST_SWAP,
		ST_FRD,
		ST_FWAIT,
		ST_FWA,
		ST_FWB,
		ST_PUSH1,
		ST_PUSH2,
		ST_ORD,
		ST_OUT
	} state_t;
endpackage

// ----- rtl/qsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qsr_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/quicksort_records_by_price_top.sv -----
// Price-ordered record sorter: top level with the sort sequencer.
// Uses qsr_pkg and qsr_ram (record store and range stack).
//
// Usage: drive a record on price_key, quantity, record_tag, last_record and
// pulse start; a request is taken when start is high and busy is low.
// While loading, busy stays low and one record is taken each cycle.
// A request with last_record high ends the set: busy rises, the store is
// sorted by price (quicksort, last element as pivot, range stack in a RAM),
// then every held record is sent out in ascending price order, marked by
// valid. end_of_run flags the last one; overflow is high on all of them if
// records beyond MAX_RECORDS were dropped. Sort time depends on the data:
// each scan step reads through the store's registered read port, each swap
// runs SWAP, FRD, FWAIT, FWA and FWB, each range runs POP, POPW, PIVR,
// PIVW, PUSH1 and PUSH2 plus its pivot swap; worst case is quadratic in
// the count. Records go out one at a time through ST_ORD and ST_OUT;
// after the last, busy falls and the block is empty again. The receiver
// cannot stall: results are shown for exactly one cycle. Reset empties
// the block; memories are not cleared as only written entries are ever read.
module quicksort_records_by_price_top
	import qsr_pkg::*;
#(
	parameter int MAX_RECORDS = MaxRecordsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [PriceW-1:0] price_key,
	input  logic [QtyW-1:0]   quantity,
	input  logic [TagW-1:0]   record_tag,
	input  logic              last_record,
	output logic              valid,
	output logic [PriceW-1:0] sorted_price,
	output logic [QtyW-1:0]   sorted_quantity,
	output logic [TagW-1:0]   sorted_tag,
	output logic              end_of_run,
	output logic              overflow
);
	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_RECORDS);

	state_t state_q, state_d;

	logic [CW-1:0] count_q, sp_q;
	logic          drop_q;
	logic [AW-1:0] lo_q, hi_q, l_q, r_q, p_q, oidx_q;
	logic [PriceW-1:0] pv_q;
	rec_t a_q;

	// store port
	logic          st_we;
	logic [AW-1:0] st_wa, st_ra;
	rec_t          st_wd, st_rd;
	// stack port
	logic            sk_we;
	logic [AW-1:0]   sk_wa, sk_ra;
	logic [2*AW-1:0] sk_wd, sk_rd;

	qsr_ram #(.Width(RecW), .Depth(MAX_RECORDS)) u_store (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
		.raddr(st_ra), .rdata(st_rd)
	);
	qsr_ram #(.Width(2 * AW), .Depth(MAX_RECORDS)) u_stack (
		.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd),
		.raddr(sk_ra), .rdata(sk_rd)
	);

	logic take;
	assign take = start && !busy;

	// signed-ish compares via widened values
	logic [CW-1:0] l_x, r_x, p_x, lo_x, hi_x;
	assign l_x  = {1'b0, l_q};
	assign r_x  = {1'b0, r_q};
	assign p_x  = {1'b0, p_q};
	assign lo_x = {1'b0, lo_q};
	assign hi_x = {1'b0, hi_q};

	// r may go to -1 only when l is 0 or above; track with a flag
	logic rneg_q;
	logic l_le_r;
	assign l_le_r = !rneg_q && (l_x <= r_x);

	// swap bookkeeping: fin=1 means final pivot swap (l,hi)
	logic fin_q;
	logic [AW-1:0] sa_q, sb_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (take && last_record) state_d = ST_INIT;
			ST_INIT:  state_d = (count_q < CW'(2)) ? ((count_q == '0) ? ST_LOAD : ST_ORD)
						: ST_POP;
			ST_POP:   state_d = (sp_q == '0) ? ST_ORD : ST_POPW;
			ST_POPW:  state_d = ST_PIVR;
			ST_PIVR:  state_d = ST_PIVW;
			ST_PIVW:  state_d = ST_LRD;
			ST_LRD:   state_d = l_le_r ? ST_LCHK : ST_RRD;
			ST_LCHK:  state_d = (st_rd.price < pv_q) ? ST_LRD : ST_RRD;
			ST_RRD:   state_d = (!rneg_q && r_x >= l_x) ? ST_RCHK : ST_SWAP;
			ST_RCHK:  state_d = (st_rd.price > pv_q) ? ST_RRD : ST_SWAP;
			ST_SWAP:  state_d = ST_FRD;
			ST_FRD:   state_d = ST_FWAIT;
			ST_FWAIT: state_d = ST_FWA;
			ST_FWA:   state_d = ST_FWB;
			ST_FWB:   state_d = fin_q ? ST_PUSH1 : ST_LRD;
			ST_PUSH1: state_d = ST_PUSH2;
			ST_PUSH2: state_d = ST_POP;
			ST_ORD:   state_d = ST_OUT;
			ST_OUT:   state_d = (CW'(oidx_q) + CW'(1) >= count_q) ? ST_LOAD : ST_ORD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		busy  = (state_q != ST_LOAD);
		st_we = 1'b0;
		st_wa = count_q[AW-1:0];
		st_wd = '{price: price_key, qty: quantity, tag: record_tag};
		st_ra = l_q;
		sk_we = 1'b0;
		sk_wa = sp_q[AW-1:0];
		sk_wd = {lo_q, hi_q};
		sk_ra = AW'(sp_q - CW'(1));
		case (state_q)
			ST_LOAD: st_we = take && (count_q < MaxCnt);
			ST_INIT: begin
				sk_we = (count_q >= CW'(2));
				sk_wa = '0;
				sk_wd = {AW'(0), AW'(count_q - CW'(1))};
			end
			ST_PIVR:  st_ra = hi_q;
			ST_LRD:   st_ra = l_q;
			ST_RRD:   st_ra = r_q;
			ST_FRD:   st_ra = sa_q;
			ST_FWAIT: st_ra = sb_q;
			ST_FWA: begin
				st_we = 1'b1; st_wa = sa_q; st_wd = st_rd;
			end
			ST_FWB: begin
				st_we = 1'b1; st_wa = sb_q; st_wd = a_q;
			end
			ST_PUSH1: begin
				sk_we = (p_x + CW'(1) < hi_x);
				sk_wd = {AW'(p_x + CW'(1)), hi_q};
			end
			ST_PUSH2: begin
				sk_we = (p_q != '0) && (lo_x < p_x - CW'(1));
				sk_wd = {lo_q, AW'(p_x - CW'(1))};
			end
			ST_ORD:   st_ra = oidx_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			sp_q    <= '0;
			drop_q  <= 1'b0;
			valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			valid   <= (state_q == ST_ORD);
			case (state_q)
				ST_LOAD: if (take) begin
					if (count_q < MaxCnt) count_q <= count_q + CW'(1);
					else drop_q <= 1'b1;
				end
				ST_INIT: begin
					sp_q <= (count_q >= CW'(2)) ? CW'(1) : '0;
					if (count_q == '0) drop_q <= 1'b0;
				end
				ST_POP: if (sp_q != '0) sp_q <= sp_q - CW'(1);
				ST_PUSH1: if (p_x + CW'(1) < hi_x) sp_q <= sp_q + CW'(1);
				ST_PUSH2: if ((p_q != '0) && (lo_x < p_x - CW'(1))) sp_q <= sp_q + CW'(1);
				ST_OUT: if (CW'(oidx_q) + CW'(1) >= count_q) begin
					count_q <= '0;
					sp_q    <= '0;
					drop_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_INIT: oidx_q <= '0;
			ST_POPW: begin
				lo_q <= sk_rd[2*AW-1:AW];
				hi_q <= sk_rd[AW-1:0];
				l_q  <= sk_rd[2*AW-1:AW];
				r_q  <= AW'(sk_rd[AW-1:0] - AW'(1));
				rneg_q <= 1'b0;
			end
			ST_PIVW: pv_q <= st_rd.price;
			ST_LCHK: if (st_rd.price < pv_q) l_q <= l_q + AW'(1);
			ST_RCHK: if (st_rd.price > pv_q) begin
				if (r_q == '0) rneg_q <= 1'b1;
				r_q <= r_q - AW'(1);
			end
			ST_SWAP: begin
				if (rneg_q || l_x >= r_x) begin
					fin_q <= 1'b1; sa_q <= l_q; sb_q <= hi_q; p_q <= l_q;
				end else begin
					fin_q <= 1'b0; sa_q <= l_q; sb_q <= r_q;
				end
			end
			ST_FWAIT: a_q <= st_rd;
			ST_FWB: if (!fin_q) begin
				l_q <= l_q + AW'(1);
				if (r_q == '0) rneg_q <= 1'b1;
				r_q <= r_q - AW'(1);
			end
			ST_OUT: oidx_q <= oidx_q + AW'(1);
			default: ;
		endcase
	end

	assign sorted_price    = st_rd.price;
	assign sorted_quantity = st_rd.qty;
	assign sorted_tag      = st_rd.tag;
	assign end_of_run      = valid && (CW'(oidx_q) + CW'(1) >= count_q);
	assign overflow        = drop_q;
endmodule

// ----- test/tb_top.sv -----
// Testbench for quicksort_records_by_price_top: loads record sets, predicts
// the sorted output with a local quicksort, checks each result in order.
// Depends on qsr_pkg and the sorter RTL.
module tb_top;
	import qsr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = MaxRecordsDef;
	localparam longint LIMIT = 3000000;

	typedef struct packed {
		logic [PriceW-1:0] price;
		logic [QtyW-1:0]   qty;
		logic [TagW-1:0]   tag;
		logic              eor;
		logic              ovf;
	} sorted_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [PriceW-1:0] price_key = '0;
	logic [QtyW-1:0] quantity = '0;
	logic [TagW-1:0] record_tag = '0;
	logic last_record = 0;
	logic busy, valid, end_of_run, overflow;
	logic [PriceW-1:0] sorted_price;
	logic [QtyW-1:0] sorted_quantity;
	logic [TagW-1:0] sorted_tag;

	quicksort_records_by_price_top dut (.*);

	always #5 clk = ~clk;

	rec_t held [CAP];
	int held_count = 0;
	bit dropped = 0;
	sorted_t sorted_q[$];
	int errors = 0;
	longint cycles = 0;
	bit gaps_on = 1;

	function automatic void swap_held(int a, int b);
		rec_t t;
		t = held[a];
		held[a] = held[b];
		held[b] = t;
	endfunction

	function automatic int partition_range(int lo, int hi);
		logic [PriceW-1:0] pv;
		int l, r;
		pv = held[hi].price;
		l = lo;
		r = hi - 1;
		forever begin
			while (l <= r && held[l].price < pv) l++;
			while (r >= l && held[r].price > pv) r--;
			if (l >= r) break;
			swap_held(l, r);
			l++;
			r--;
		end
		swap_held(l, hi);
		return l;
	endfunction

	// explicit range stack so equal keys land exactly where the hardware puts them
	function automatic void sort_held();
		int lo_s[$], hi_s[$];
		int lo, hi, p;
		if (held_count < 2) return;
		lo_s.push_back(0);
		hi_s.push_back(held_count - 1);
		while (lo_s.size() > 0) begin
			lo = lo_s.pop_back();
			hi = hi_s.pop_back();
			p = partition_range(lo, hi);
			if (p + 1 < hi) begin
				lo_s.push_back(p + 1);
				hi_s.push_back(hi);
			end
			if (lo < p - 1) begin
				lo_s.push_back(lo);
				hi_s.push_back(p - 1);
			end
		end
	endfunction

	function automatic void predict_record(rec_t r, bit last);
		sorted_t s;
		if (held_count < CAP) begin
			held[held_count] = r;
			held_count++;
		end else
			dropped = 1;
		if (!last) return;
		sort_held();
		for (int i = 0; i < held_count; i++) begin
			s.price = held[i].price;
			s.qty = held[i].qty;
			s.tag = held[i].tag;
			s.eor = (i + 1 == held_count);
			s.ovf = dropped;
			sorted_q.push_back(s);
		end
		held_count = 0;
		dropped = 0;
	endfunction

	// start stays high between back-to-back requests; it drops only for idling
	task automatic send_record(logic [PriceW-1:0] p, logic [QtyW-1:0] q,
			logic [TagW-1:0] t, bit last);
		rec_t r;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		price_key <= p;
		quantity <= q;
		record_tag <= t;
		last_record <= last;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		r.price = p;
		r.qty = q;
		r.tag = t;
		predict_record(r, last);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 0;
		while (sorted_q.size() > 0 || busy) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	function automatic logic [PriceW-1:0] rand_price(int mode);
		case (mode)
			0: return $urandom_range(0, 7);
			1: return $urandom;
			default: return {$urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0} | $urandom_range(0, 15);
		endcase
	endfunction

	task automatic send_set(int n, int mode);
		for (int i = 0; i < n; i++)
			send_record(rand_price(mode), QtyW'($urandom), TagW'($urandom), i == n - 1);
	endtask

	task automatic test_extremes();
		send_record('0, '0, '0, 1'b1);
		send_record('1, '1, '1, 1'b0);
		send_record('0, 16'h5555, 6'h2A, 1'b0);
		send_record(32'hAAAA_AAAA, 16'hAAAA, 6'h15, 1'b0);
		send_record(32'h5555_5555, 16'h1234, 6'h3F, 1'b0);
		send_record('1, 16'h0, 6'h0, 1'b1);
		wait_drained();
	endtask

	task automatic test_orders();
		for (int i = 0; i < 6; i++)
			send_record(PriceW'(i), QtyW'(i), TagW'(i), i == 5);
		for (int i = 0; i < 6; i++)
			send_record(PriceW'(10 - i), QtyW'(i), TagW'(i), i == 5);
		for (int i = 0; i < 6; i++)
			send_record(PriceW'(7), QtyW'(i), TagW'(i), i == 5);
		wait_drained();
	endtask

	task automatic test_overflow();
		send_set(CAP, 1);
		send_set(CAP + 3, 0);
		for (int i = 0; i < CAP + 1; i++)
			send_record($urandom, QtyW'(i), TagW'(i), i == CAP);
		wait_drained();
	endtask

	task automatic test_random();
		int n;
		for (int k = 0; k < 15; k++) begin
			if (k == 11) gaps_on = 0;
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, CAP) : $urandom_range(1, 12);
			send_set(n, $urandom_range(0, 2));
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		sorted_t e;
		if (arst_n && valid) begin
			if (sorted_q.size() == 0) begin
				$display("%0t: unexpected result exp none act price %h", $time, sorted_price);
				errors++;
			end else begin
				e = sorted_q.pop_front();
				if (sorted_price !== e.price || sorted_quantity !== e.qty ||
						sorted_tag !== e.tag || end_of_run !== e.eor ||
						overflow !== e.ovf) begin
					$display("%0t: mismatch exp %h/%h/%h/%b/%b act %h/%h/%h/%b/%b", $time,
						e.price, e.qty, e.tag, e.eor, e.ovf, sorted_price,
						sorted_quantity, sorted_tag, end_of_run, overflow);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_extremes();
		test_orders();
		test_overflow();
		test_random();
		if (errors == 0 && sorted_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/qsr_pkg.sv
rtl/qsr_ram.sv
rtl/quicksort_records_by_price_top.sv
test/tb_top.sv
